// File: hw/rtl/bpdc_pkg.sv
// shared types, constants and register codes of the button press duration classifier
`default_nettype none
package bpdc_pkg;

    localparam int DEF_CHANNELS = 4;

    localparam int CH_W   = 2;
    localparam int TIME_W = 32;
    localparam int LIM_W  = 16;
    localparam int CFG_W  = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [LIM_W-1:0] SHORT_MS_RST  = 16'd500;
    localparam logic [LIM_W-1:0] MEDIUM_MS_RST = 16'd2000;
    localparam logic [LIM_W-1:0] LONG_MS_RST   = 16'd5000;

    typedef enum logic [2:0] {
        CFG_PUBLISH_MODES  = 3'd0,
        CFG_TRIGGER_ENABLE = 3'd1,
        CFG_INVERT_MASK    = 3'd2,
        CFG_SHORT_MS       = 3'd3,
        CFG_MEDIUM_MS      = 3'd4,
        CFG_LONG_MS        = 3'd5
    } t_cfg_reg;

    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_ANY  = 2'd2;

    localparam logic [1:0] SLOT_SHORT     = 2'd0;
    localparam logic [1:0] SLOT_MEDIUM    = 2'd1;
    localparam logic [1:0] SLOT_LONG      = 2'd2;
    localparam logic [1:0] SLOT_VERY_LONG = 2'd3;

endpackage
`default_nettype wire

// File: hw/rtl/bpdc_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module bpdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/button_press_duration_classifier.sv
// top level: per-channel button change detection and press duration classification
// One sample is taken per clock cycle, back to back, while no result waits on a stalled
// output; a result is registered via the compute stage. The per-channel last level and
// change time sit in one ram with a single read and a single write port: the read is
// issued when a sample is accepted, the compare, subtract and threshold cascade run in
// the next cycle and the updated entry is written back at its end. A forwarding
// register covers a sample that follows another of the same channel directly. The ram
// needs no clearing pass: per-entry valid bits make unwritten channels read as zero.
// When the output is stalled only a sample that produces a result waits; samples that
// produce none keep flowing.
`default_nettype none
module button_press_duration_classifier
    import bpdc_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // slave stream: channel[1:0], level[2], now_ms[34:3], zero fill
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // master stream: event_channel[1:0], new_level[2], reported_state[3],
    // held_ms[35:4], trigger_fired[36], trigger_slot[38:37], zero fill
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic      [OUT_TDATA_W-1:0] o_m_tdata,
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = TIME_W + 1;

    // configuration registers
    logic [7:0]       r_pm;
    logic [15:0]      r_te;
    logic [3:0]       r_inv;
    logic [LIM_W-1:0] r_short;
    logic [LIM_W-1:0] r_medium;
    logic [LIM_W-1:0] r_long;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm     <= '0;
            r_te     <= '0;
            r_inv    <= '0;
            r_short  <= SHORT_MS_RST;
            r_medium <= MEDIUM_MS_RST;
            r_long   <= LONG_MS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PUBLISH_MODES:  r_pm     <= i_cfg_data[7:0];
                CFG_TRIGGER_ENABLE: r_te     <= i_cfg_data[15:0];
                CFG_INVERT_MASK:    r_inv    <= i_cfg_data[3:0];
                CFG_SHORT_MS:       r_short  <= i_cfg_data[LIM_W-1:0];
                CFG_MEDIUM_MS:      r_medium <= i_cfg_data[LIM_W-1:0];
                CFG_LONG_MS:        r_long   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // input unpack
    logic [CH_W-1:0]   in_ch;
    logic              in_level;
    logic [TIME_W-1:0] in_now;
    logic              in_acc;

    assign in_ch    = i_s_tdata[1:0];
    assign in_level = i_s_tdata[2];
    assign in_now   = i_s_tdata[34:3];
    assign in_acc   = i_s_tvalid && o_s_tready;

    // state ram
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    bpdc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (AW'(in_ch)),
        .o_rdata (ram_rdata)
    );

    // compute stage
    logic              r_s1_valid;
    logic [CH_W-1:0]   r_s1_ch;
    logic              r_s1_level;
    logic [TIME_W-1:0] r_s1_now;

    logic [CHANNELS-1:0] r_vld;

    logic              r_fwd_valid;
    logic [CH_W-1:0]   r_fwd_ch;
    logic              r_fwd_level;
    logic [TIME_W-1:0] r_fwd_time;

    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic              s1_ok;
    logic              fwd_hit;
    logic              prev_level;
    logic [TIME_W-1:0] prev_time;
    logic              changed;
    logic [TIME_W-1:0] held;
    logic [1:0]        mode;
    logic [3:0]        en;
    logic              inv;
    logic              report;
    logic              fired;
    logic [1:0]        slot;
    logic              result;
    logic              out_free;
    logic              s1_fire;

    assign s1_ok     = 32'(r_s1_ch) < CHANNELS;
    assign fwd_hit   = r_fwd_valid && (r_fwd_ch == r_s1_ch);
    assign ram_waddr = AW'(r_s1_ch);

    always_comb begin
        if (fwd_hit) begin
            prev_level = r_fwd_level;
            prev_time  = r_fwd_time;
        end else if (r_vld[ram_waddr]) begin
            prev_level = ram_rdata[TIME_W];
            prev_time  = ram_rdata[TIME_W-1:0];
        end else begin
            prev_level = 1'b0;
            prev_time  = '0;
        end
    end

    assign changed = s1_ok && (r_s1_level != prev_level);
    assign held    = r_s1_now - prev_time;
    assign mode    = 2'(r_pm >> {r_s1_ch, 1'b0});
    assign en      = 4'(r_te >> {r_s1_ch, 2'b00});
    assign inv     = r_inv[r_s1_ch];

    always_comb begin
        report = 1'b0;
        fired  = 1'b0;
        slot   = SLOT_SHORT;
        if (mode == MODE_ANY && held > TIME_W'(r_short)) begin
            report = 1'b1;
            fired  = en[0];
        end else if ({1'b0, r_s1_level} == mode) begin
            report = 1'b1;
            if (held < TIME_W'(r_short) && en[0]) begin
                fired = 1'b1;
                slot  = SLOT_SHORT;
            end else if (held < TIME_W'(r_medium) && en[1]) begin
                fired = 1'b1;
                slot  = SLOT_MEDIUM;
            end else if (held < TIME_W'(r_long) && en[2]) begin
                fired = 1'b1;
                slot  = SLOT_LONG;
            end else if (held > TIME_W'(r_long) && en[3]) begin
                fired = 1'b1;
                slot  = SLOT_VERY_LONG;
            end
        end
    end

    assign result     = changed && report;
    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && (!result || out_free);
    assign o_s_tready = !r_s1_valid || s1_fire;
    assign ram_we     = s1_fire && changed;
    assign ram_wdata  = {r_s1_level, r_s1_now};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_vld       <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
                r_fwd_valid      <= 1'b1;
            end
            if (s1_fire && result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ch    <= in_ch;
            r_s1_level <= in_level;
            r_s1_now   <= in_now;
        end
        if (ram_we) begin
            r_fwd_ch    <= r_s1_ch;
            r_fwd_level <= r_s1_level;
            r_fwd_time  <= r_s1_now;
        end
        if (s1_fire && result) begin
            r_out_data <= {1'b0, slot, fired, held, r_s1_level ^ inv, r_s1_level, r_s1_ch};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

// File: hw/rtl/bpdc_checker.sv
// port-level checks of the button press duration classifier and their binding
`default_nettype none
module bpdc_checker
    import bpdc_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output transaction dropped or changed while stalled");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // only channels that exist are reported
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> 32'(o_m_tdata[1:0]) < CHANNELS)
        else $error("event on a channel beyond the configured count");

    // no slot code without a firing
    a_slot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[36] |-> o_m_tdata[38:37] == SLOT_SHORT)
        else $error("slot set although no trigger fired");

    // fill bit stays clear
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_TDATA_W-1] == 1'b0)
        else $error("fill bit of output data set");

endmodule

bind button_press_duration_classifier bpdc_checker #(
    .CHANNELS (CHANNELS)
) u_bpdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// File: bench/testbench.sv
// self-checking testbench for the button press duration classifier
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import bpdc_pkg::*;
;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         PHASE_ITEMS   = 100;
    localparam int         PHASES        = 6;
    localparam int         HOLD_AT       = 250;
    localparam int         HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [1:0]        slot;
        logic              fired;
        logic [TIME_W-1:0] held;
        logic              state;
        logic              level;
        logic [CH_W-1:0]   ch;
    } t_press_event;

    class t_press_scoreboard;
        logic [7:0]        publish_modes;
        logic [15:0]       trigger_enable;
        logic [3:0]        invert_mask;
        logic [LIM_W-1:0]  short_ms;
        logic [LIM_W-1:0]  medium_ms;
        logic [LIM_W-1:0]  long_ms;
        logic              last_level [DEF_CHANNELS];
        logic [TIME_W-1:0] last_time [DEF_CHANNELS];
        t_press_event      pending_events [$];
        int                errors;
        int                checked;
        int                fired_count;

        function new();
            publish_modes  = '0;
            trigger_enable = '0;
            invert_mask    = '0;
            short_ms       = SHORT_MS_RST;
            medium_ms      = MEDIUM_MS_RST;
            long_ms        = LONG_MS_RST;
            foreach (last_level[c]) begin
                last_level[c] = 1'b0;
                last_time[c]  = '0;
            end
            errors      = 0;
            checked     = 0;
            fired_count = 0;
        endfunction

        function void apply_register(t_cfg_reg idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PUBLISH_MODES:  publish_modes  = data[7:0];
                CFG_TRIGGER_ENABLE: trigger_enable = data;
                CFG_INVERT_MASK:    invert_mask    = data[3:0];
                CFG_SHORT_MS:       short_ms       = data;
                CFG_MEDIUM_MS:      medium_ms      = data;
                CFG_LONG_MS:        long_ms        = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [CH_W-1:0] ch, logic lvl, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] held;
            logic [1:0]        mode;
            logic [3:0]        en;
            bit                report;
            t_press_event      ev;
            if (lvl == last_level[ch])
                return;
            held     = now - last_time[ch];
            mode     = publish_modes[2*ch +: 2];
            en       = trigger_enable[4*ch +: 4];
            report   = 1'b0;
            ev       = '0;
            ev.ch    = ch;
            ev.level = lvl;
            ev.state = lvl ^ invert_mask[ch];
            ev.held  = held;
            ev.slot  = SLOT_SHORT;
            if (mode == MODE_ANY && held > short_ms) begin
                report   = 1'b1;
                ev.fired = en[0];
            end else if ({1'b0, lvl} == mode) begin
                report = 1'b1;
                if (held < short_ms && en[0]) begin
                    ev.fired = 1'b1;
                    ev.slot  = SLOT_SHORT;
                end else if (held < medium_ms && en[1]) begin
                    ev.fired = 1'b1;
                    ev.slot  = SLOT_MEDIUM;
                end else if (held < long_ms && en[2]) begin
                    ev.fired = 1'b1;
                    ev.slot  = SLOT_LONG;
                end else if (held > long_ms && en[3]) begin
                    ev.fired = 1'b1;
                    ev.slot  = SLOT_VERY_LONG;
                end
            end
            last_level[ch] = lvl;
            last_time[ch]  = now;
            if (report)
                pending_events.push_back(ev);
        endfunction

        function void check_event(logic [OUT_TDATA_W-1:0] tdata);
            t_press_event got;
            t_press_event want;
            got = tdata[$bits(t_press_event)-1:0];
            if (pending_events.size() == 0) begin
                errors++;
                $error("result with nothing expected: tdata %h", tdata);
                return;
            end
            want = pending_events.pop_front();
            checked++;
            if (got.fired)
                fired_count++;
            if (got.ch !== want.ch) begin
                errors++;
                $error("event_channel: expected %0d, got %0d", want.ch, got.ch);
            end
            if (got.level !== want.level) begin
                errors++;
                $error("new_level: expected %0d, got %0d", want.level, got.level);
            end
            if (got.state !== want.state) begin
                errors++;
                $error("reported_state: expected %0d, got %0d", want.state, got.state);
            end
            if (got.held !== want.held) begin
                errors++;
                $error("held_ms: expected %0d, got %0d", want.held, got.held);
            end
            if (got.fired !== want.fired) begin
                errors++;
                $error("trigger_fired: expected %0d, got %0d", want.fired, got.fired);
            end
            if (got.slot !== want.slot) begin
                errors++;
                $error("trigger_slot: expected %0d, got %0d", want.slot, got.slot);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [2:0]             i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    t_press_scoreboard sb = new();
    int                samples_sent = 0;
    int                settings_used = 0;
    int                burst_left = 0;
    bit                hold_done = 1'b0;

    button_press_duration_classifier #(
        .CHANNELS (DEF_CHANNELS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(logic [CH_W-1:0] ch, logic lvl, logic [TIME_W-1:0] now);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W-35){1'b0}}, now, lvl, ch};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_sample(ch, lvl, now);
        samples_sent++;
    endtask

    task automatic random_sample();
        logic [CH_W-1:0]   ch;
        logic              lvl;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] now;
        int                pick;
        ch   = CH_W'($urandom_range(0, DEF_CHANNELS - 1));
        lvl  = ($urandom_range(0, 4) != 0) ? ~sb.last_level[ch] : sb.last_level[ch];
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            now = $urandom;
        end else begin
            case (pick)
                1, 2:    delta = $urandom_range(0, 7000);
                3, 4:    delta = TIME_W'(sb.short_ms);
                5, 6:    delta = TIME_W'(sb.medium_ms);
                7, 8:    delta = TIME_W'(sb.long_ms);
                default: delta = $urandom;
            endcase
            // land on either side of a limit and right on it
            if (pick >= 3 && pick <= 8)
                delta = delta + $urandom_range(0, 4) - 2;
            now = sb.last_time[ch] + delta;
        end
        send_sample(ch, lvl, now);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.apply_register(idx, data);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] pm, logic [CFG_W-1:0] te,
                                logic [CFG_W-1:0] im, logic [CFG_W-1:0] sh,
                                logic [CFG_W-1:0] md, logic [CFG_W-1:0] lg);
        write_reg(CFG_PUBLISH_MODES, pm);
        write_reg(CFG_TRIGGER_ENABLE, te);
        write_reg(CFG_INVERT_MASK, im);
        write_reg(CFG_SHORT_MS, sh);
        write_reg(CFG_MEDIUM_MS, md);
        write_reg(CFG_LONG_MS, lg);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic program_phase(int p);
        logic [CFG_W-1:0] pm;
        logic [CFG_W-1:0] te;
        logic [CFG_W-1:0] im;
        logic [CFG_W-1:0] sh;
        logic [CFG_W-1:0] md;
        logic [CFG_W-1:0] lg;
        pm = CFG_W'($urandom);
        te = CFG_W'($urandom);
        im = CFG_W'($urandom);
        sh = CFG_W'($urandom_range(0, 1000));
        md = CFG_W'(sh + $urandom_range(0, 3000));
        lg = CFG_W'(md + $urandom_range(0, 6000));
        case (p)
            1: begin
                pm = CFG_W'({4{MODE_ANY}});
                te = 16'hFFFF;
                im = 16'h000F;
                sh = '0;
                md = '0;
                lg = '0;
            end
            2: begin
                pm = CFG_W'({4{MODE_HIGH}});
                te = 16'hFFFF;
                im = '0;
                sh = 16'hFFFF;
                md = 16'hFFFF;
                lg = 16'hFFFF;
            end
            3: begin
                pm = CFG_W'({4{MODE_LOW}});
                te = '0;
            end
            4: begin
                sh = CFG_W'($urandom);
                md = CFG_W'($urandom);
                lg = CFG_W'($urandom);
            end
            default: ;
        endcase
        program_regs(pm, te, im, sh, md, lg);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random back-pressure plus one long hold while samples keep coming
    initial begin
        int gap;
        i_m_tready <= 1'b0;
        forever begin
            if (!hold_done && samples_sent >= HOLD_AT) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                gap = idle_len();
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 200)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_event(o_m_tdata);
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // {now_ms, level, channel}
    logic [34:0] directed_samples [21] = '{
        {32'd100,          1'b1, 2'd0},
        {32'd300,          1'b0, 2'd0},
        {32'd1000,         1'b1, 2'd0},
        {32'd2000,         1'b0, 2'd0},
        {32'd3000,         1'b1, 2'd0},
        {32'd6000,         1'b0, 2'd0},
        {32'd7000,         1'b1, 2'd0},
        {32'd20000,        1'b0, 2'd0},
        {32'd20001,        1'b0, 2'd0},
        {32'd5000,         1'b1, 2'd1},
        {32'd5100,         1'b0, 2'd1},
        {32'd5050,         1'b1, 2'd1},
        {32'd500,          1'b1, 2'd2},
        {32'd1001,         1'b0, 2'd2},
        {32'd1001,         1'b1, 2'd2},
        {32'hFFFF_FFFF,    1'b1, 2'd3},
        {32'd0,            1'b0, 2'd3},
        {32'hFFFF_FFFF,    1'b1, 2'd0},
        {32'h0000_0010,    1'b0, 2'd0},
        {32'h8000_0000,    1'b1, 2'd1},
        {32'h7FFF_FFFF,    1'b0, 2'd1}
    };

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PUBLISH_MODES;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // settings after reset: report on low, no slot enabled
        send_sample(2'd0, 1'b1, 32'd10);
        send_sample(2'd0, 1'b0, 32'd20);
        drain();

        // channel 0 low, 1 high, 2 any edge, 3 unused
        program_regs({8'h00, MODE_UNUSED, MODE_ANY, MODE_HIGH, MODE_LOW},
                     16'hF1CF, 16'h0005, SHORT_MS_RST, MEDIUM_MS_RST, LONG_MS_RST);
        foreach (directed_samples[i])
            send_sample(directed_samples[i][1:0], directed_samples[i][2],
                        directed_samples[i][34:3]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            program_phase(p);
            repeat (PHASE_ITEMS) random_sample();
            drain();
        end

        $display("%0d samples over %0d register settings", samples_sent, settings_used);
        $display("%0d events checked, %0d with a trigger, output held off for %0d cycles once",
                 sb.checked, sb.fired_count, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
